@@ rtl/jisd_pkg.sv @@
package jisd_pkg;

  localparam int unsigned ERR_OFFSET_W = 32;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_TRUNC_ESC   = 3'd0,
    ERR_UNSUP_ESC   = 3'd1,
    ERR_HIGH_BYTE   = 3'd2,
    ERR_TRUNC_PAIR  = 3'd3,
    ERR_INVALID_PAIR = 3'd4
  } err_code_t;

  localparam logic [7:0] BYTE_ESC    = 8'h1b;
  localparam logic [7:0] BYTE_CR     = 8'h0d;
  localparam logic [7:0] BYTE_LF     = 8'h0a;
  localparam logic [7:0] ASCII_MAX   = 8'h7f;
  localparam logic [7:0] CH_K        = 8'h4b;
  localparam logic [7:0] CH_H        = 8'h48;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_J        = 8'h4a;
  localparam logic [7:0] PAIR_MIN    = 8'h21;
  localparam logic [7:0] PAIR_MAX    = 8'h7e;

  function automatic logic in_pair_range(input logic [7:0] b);
    in_pair_range = (b >= PAIR_MIN) && (b <= PAIR_MAX);
  endfunction

endpackage

@@ rtl/jisd_ifs.sv @@
interface jisd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_stream;

  modport source (output valid, output byte_value, output end_of_stream, input ready);
  modport sink   (input valid, input byte_value, input end_of_stream, output ready);
endinterface

interface jisd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] value;
  logic [2:0]  error_code;
  logic [31:0] error_offset;

  modport source (output valid, output kind, output value, output error_code,
                  output error_offset, input ready);
  modport sink   (input valid, input kind, input value, input error_code,
                  input error_offset, output ready);
endinterface

@@ rtl/jis_escape_stream_decoder.sv @@
// channel   direction  payload
// in_ch     sink       byte_value[7:0], end_of_stream
// out_ch    source     kind[1:0], value[15:0], error_code[2:0], error_offset[31:0]
//
// One byte per clock: a result shows on out_ch the cycle after its byte is taken.
// The single output register sets the pace; in_ch.ready is low only while a
// result waits and out_ch.ready is low.
// Reset (rst_n low, synchronous) returns to single-byte mode at offset zero.
// Bytes after an error give no result up to and including the end-of-stream byte.
module jis_escape_stream_decoder #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  jisd_in_if.sink    in_ch,
  jisd_out_if.source out_ch
);
  import jisd_pkg::*;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_SEEN,
    ESC_DOLLAR,
    ESC_PAREN
  } esc_stage_t;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  esc_stage_t             esc_stage_r, esc_stage_nxt;
  logic                   two_byte_r, two_byte_nxt;
  logic                   lead_pending_r, lead_pending_nxt;
  logic [7:0]             held_lead_r, held_lead_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] unit_start_r, unit_start_nxt;
  logic                   halted_r, halted_nxt;

  logic                   out_valid_r, out_valid_nxt;
  kind_t                  kind_r, kind_nxt;
  logic [15:0]            value_r, value_nxt;
  err_code_t              err_code_r, err_code_nxt;
  logic [ERR_OFFSET_W-1:0] err_off_r, err_off_nxt;

  logic                    in_fire;
  logic [7:0]              b;
  logic                    eos;
  logic [ERR_OFFSET_W-1:0] pos_lo;
  logic [ERR_OFFSET_W-1:0] start_lo;

  generate
    if (OFFSET_BITS >= ERR_OFFSET_W) begin : g_off_trunc
      assign pos_lo   = pos_r[ERR_OFFSET_W-1:0];
      assign start_lo = unit_start_r[ERR_OFFSET_W-1:0];
    end else begin : g_off_ext
      assign pos_lo   = {{(ERR_OFFSET_W-OFFSET_BITS){1'b0}}, pos_r};
      assign start_lo = {{(ERR_OFFSET_W-OFFSET_BITS){1'b0}}, unit_start_r};
    end
  endgenerate

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.byte_value;
  assign eos         = in_ch.end_of_stream;

  always_comb begin
    esc_stage_t             stage_v;
    logic                   res_v;
    kind_t                  kind_v;
    logic [15:0]            value_v;
    err_code_t              code_v;
    logic [ERR_OFFSET_W-1:0] off_v;
    logic                   err_v;

    esc_stage_nxt    = esc_stage_r;
    two_byte_nxt     = two_byte_r;
    lead_pending_nxt = lead_pending_r;
    held_lead_nxt    = held_lead_r;
    pos_nxt          = pos_r;
    unit_start_nxt   = unit_start_r;
    halted_nxt       = halted_r;
    stage_v          = esc_stage_r;
    res_v            = 1'b0;
    kind_v           = KIND_CHAR;
    value_v          = '0;
    code_v           = ERR_TRUNC_ESC;
    off_v            = '0;
    err_v            = 1'b0;

    if (!halted_r) begin
      case (esc_stage_r)
        ESC_SEEN: begin
          if (b == CH_K) begin
            two_byte_nxt = 1'b1;
            stage_v      = ESC_NONE;
          end else if (b == CH_H) begin
            two_byte_nxt = 1'b0;
            stage_v      = ESC_NONE;
          end else if (b == CH_DOLLAR || b == CH_LPAREN) begin
            stage_v = (b == CH_DOLLAR) ? ESC_DOLLAR : ESC_PAREN;
            if (eos) begin
              err_v  = 1'b1;
              code_v = ERR_TRUNC_ESC;
              off_v  = start_lo;
            end
          end else begin
            err_v  = 1'b1;
            code_v = ERR_UNSUP_ESC;
            off_v  = start_lo;
          end
        end
        ESC_DOLLAR: begin
          stage_v = ESC_NONE;
          if (b == CH_B || b == CH_AT) begin
            two_byte_nxt = 1'b1;
          end else begin
            err_v  = 1'b1;
            code_v = ERR_UNSUP_ESC;
            off_v  = start_lo;
          end
        end
        ESC_PAREN: begin
          stage_v = ESC_NONE;
          if (b == CH_B || b == CH_J) begin
            two_byte_nxt = 1'b0;
          end else begin
            err_v  = 1'b1;
            code_v = ERR_UNSUP_ESC;
            off_v  = start_lo;
          end
        end
        ESC_NONE: begin
          if (lead_pending_r) begin
            // trail byte is taken as is, even ESC, CR or LF
            lead_pending_nxt = 1'b0;
            if (in_pair_range(held_lead_r) && in_pair_range(b)) begin
              res_v   = 1'b1;
              kind_v  = KIND_PAIR;
              value_v = {held_lead_r, b};
            end else begin
              err_v  = 1'b1;
              code_v = ERR_INVALID_PAIR;
              off_v  = start_lo;
            end
          end else if (b == BYTE_ESC) begin
            unit_start_nxt = pos_r;
            stage_v        = ESC_SEEN;
            if (eos) begin
              err_v  = 1'b1;
              code_v = ERR_TRUNC_ESC;
              off_v  = pos_lo;
            end
          end else if (b == BYTE_CR || b == BYTE_LF) begin
            two_byte_nxt = 1'b0;
            res_v        = 1'b1;
            value_v      = {8'h00, b};
          end else if (!two_byte_r) begin
            if (b > ASCII_MAX) begin
              err_v  = 1'b1;
              code_v = ERR_HIGH_BYTE;
              off_v  = pos_lo;
            end else begin
              res_v   = 1'b1;
              value_v = {8'h00, b};
            end
          end else if (eos) begin
            err_v  = 1'b1;
            code_v = ERR_TRUNC_PAIR;
            off_v  = pos_lo;
          end else begin
            held_lead_nxt    = b;
            lead_pending_nxt = 1'b1;
            unit_start_nxt   = pos_r;
          end
        end
        default: begin
          stage_v = ESC_NONE;
        end
      endcase
    end

    if (err_v) begin
      res_v      = 1'b1;
      kind_v     = KIND_ERROR;
      value_v    = '0;
      halted_nxt = 1'b1;
    end else begin
      code_v = ERR_TRUNC_ESC;
      off_v  = '0;
    end
    esc_stage_nxt = stage_v;

    // end of stream: drop all stream state
    if (eos) begin
      esc_stage_nxt    = ESC_NONE;
      two_byte_nxt     = 1'b0;
      lead_pending_nxt = 1'b0;
      pos_nxt          = '0;
      unit_start_nxt   = '0;
      halted_nxt       = 1'b0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + OFFSET_BITS'(1);
    end

    kind_nxt     = kind_v;
    value_nxt    = value_v;
    err_code_nxt = code_v;
    err_off_nxt  = off_v;

    if (in_fire) begin
      out_valid_nxt = res_v;
    end else begin
      out_valid_nxt = out_valid_r && !out_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_stage_r    <= ESC_NONE;
      two_byte_r     <= 1'b0;
      lead_pending_r <= 1'b0;
      pos_r          <= '0;
      unit_start_r   <= '0;
      halted_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        esc_stage_r    <= esc_stage_nxt;
        two_byte_r     <= two_byte_nxt;
        lead_pending_r <= lead_pending_nxt;
        pos_r          <= pos_nxt;
        unit_start_r   <= unit_start_nxt;
        halted_r       <= halted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_lead_r <= held_lead_nxt;
      kind_r      <= kind_nxt;
      value_r     <= value_nxt;
      err_code_r  <= err_code_nxt;
      err_off_r   <= err_off_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.value        = value_r;
  assign out_ch.error_code   = err_code_r;
  assign out_ch.error_offset = err_off_r;

`ifndef SYNTHESIS
  a_lead_in_two_byte: assert property (@(posedge clk) disable iff (!rst_n)
    lead_pending_r |-> (two_byte_r && esc_stage_r == ESC_NONE))
    else $error("lead pending outside two-byte mode or inside an escape");

  a_halt_no_lead: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !lead_pending_r)
    else $error("lead byte held while halted");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && eos) |=> (pos_r == '0 && !halted_r && esc_stage_r == ESC_NONE))
    else $error("stream state not cleared after end of stream");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && halted_r) |=> !out_valid_r)
    else $error("result produced while halted");

  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r != KIND_ERROR) |-> (err_off_r == '0 && err_code_r == ERR_TRUNC_ESC))
    else $error("error fields set on a character result");
`endif

endmodule

@@ test/jisd_stream_checker.sv @@
module jisd_stream_checker #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  jisd_in_if   in_mon,
  jisd_out_if  out_mon,
  output int   pending,
  output int   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import jisd_pkg::*;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_OPEN,
    ESC_DOLLAR,
    ESC_PAREN
  } esc_stage_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] value;
    err_code_t   code;
    logic [31:0] offset;
  } symbol_t;

  symbol_t                expected_q[$];
  logic                   two_mode;
  esc_stage_t             esc_stage;
  logic                   lead_held;
  logic [7:0]             lead_byte;
  logic [OFFSET_BITS-1:0] byte_pos;
  logic [OFFSET_BITS-1:0] unit_pos;
  logic                   halted;

  task automatic emit_char(input kind_t kind, input logic [15:0] value);
    symbol_t s;
    s.kind   = kind;
    s.value  = value;
    s.code   = ERR_TRUNC_ESC;
    s.offset = '0;
    expected_q.insert(expected_q.size(), s);
  endtask

  task automatic emit_error(input err_code_t code, input logic [OFFSET_BITS-1:0] where);
    symbol_t s;
    s.kind   = KIND_ERROR;
    s.value  = '0;
    s.code   = code;
    s.offset = 32'(where);
    expected_q.insert(expected_q.size(), s);
    halted = 1'b1;
  endtask

  function automatic logic pair_byte_ok(input logic [7:0] b);
    return (b >= PAIR_MIN) && (b <= PAIR_MAX);
  endfunction

  task automatic clear_stream();
    two_mode  = 1'b0;
    esc_stage = ESC_NONE;
    lead_held = 1'b0;
    lead_byte = '0;
    byte_pos  = '0;
    unit_pos  = '0;
    halted    = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eos);
    logic [OFFSET_BITS-1:0] here;
    here = byte_pos;
    if (!halted) begin
      if (esc_stage == ESC_OPEN) begin
        if (b == CH_K) begin
          two_mode  = 1'b1;
          esc_stage = ESC_NONE;
        end else if (b == CH_H) begin
          two_mode  = 1'b0;
          esc_stage = ESC_NONE;
        end else if (b == CH_DOLLAR || b == CH_LPAREN) begin
          esc_stage = (b == CH_DOLLAR) ? ESC_DOLLAR : ESC_PAREN;
          if (eos) emit_error(ERR_TRUNC_ESC, unit_pos);
        end else begin
          emit_error(ERR_UNSUP_ESC, unit_pos);
        end
      end else if (esc_stage == ESC_DOLLAR) begin
        esc_stage = ESC_NONE;
        if (b == CH_B || b == CH_AT) two_mode = 1'b1;
        else emit_error(ERR_UNSUP_ESC, unit_pos);
      end else if (esc_stage == ESC_PAREN) begin
        esc_stage = ESC_NONE;
        if (b == CH_B || b == CH_J) two_mode = 1'b0;
        else emit_error(ERR_UNSUP_ESC, unit_pos);
      end else if (lead_held) begin
        // the trail is taken as is, even ESC, CR or LF
        lead_held = 1'b0;
        if (pair_byte_ok(lead_byte) && pair_byte_ok(b)) emit_char(KIND_PAIR, {lead_byte, b});
        else emit_error(ERR_INVALID_PAIR, unit_pos);
      end else if (b == BYTE_ESC) begin
        unit_pos  = here;
        esc_stage = ESC_OPEN;
        if (eos) emit_error(ERR_TRUNC_ESC, unit_pos);
      end else if (b == BYTE_CR || b == BYTE_LF) begin
        two_mode = 1'b0;
        emit_char(KIND_CHAR, {8'h00, b});
      end else if (!two_mode) begin
        if (b > ASCII_MAX) emit_error(ERR_HIGH_BYTE, here);
        else emit_char(KIND_CHAR, {8'h00, b});
      end else if (eos) begin
        emit_error(ERR_TRUNC_PAIR, here);
      end else begin
        lead_byte = b;
        lead_held = 1'b1;
        unit_pos  = here;
      end
    end
    if (eos) clear_stream();
    else if (byte_pos != '1) byte_pos = byte_pos + OFFSET_BITS'(1);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    symbol_t want;
    if (!rst_n) begin
      clear_stream();
      expected_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) decode_byte(in_mon.byte_value, in_mon.end_of_stream);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: kind %0h value %0h", out_mon.kind,
                 out_mon.value);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_mon.kind));
          check_field("value", 32'(want.value), 32'(out_mon.value));
          check_field("error_code", 32'(want.code), 32'(out_mon.error_code));
          check_field("error_offset", want.offset, out_mon.error_offset);
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

@@ test/jis_escape_stream_decoder_tb.sv @@
module jis_escape_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jisd_pkg::*;

  // narrow offset, zero-extended onto the 32-bit error offset
  localparam int unsigned POS_BITS   = 16;
  localparam int          QUIET_MAX  = 2000;
  localparam int          PHASE_SIZE = 225;

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle;
  int   recv_stall;
  int   sent;
  int   quiet;
  int   pending;
  int   fail_count;
  logic [7:0] stream_q[$];

  jisd_in_if  in_ch();
  jisd_out_if out_ch();

  jis_escape_stream_decoder #(.OFFSET_BITS(POS_BITS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  jisd_stream_checker #(.OFFSET_BITS(POS_BITS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.byte_value    <= b;
    in_ch.end_of_stream <= eos;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  task automatic add_byte(input logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endtask

  // mostly well-formed units with random content, some broken escapes and noise
  task automatic make_stream();
    int   units;
    int   pick;
    logic two;
    stream_q.delete();
    two   = 1'b0;
    units = $urandom_range(1, 12);
    repeat (units) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if (two && $urandom_range(0, 9) != 0) begin
          add_byte(8'($urandom_range(PAIR_MIN, PAIR_MAX)));
          add_byte(8'($urandom_range(PAIR_MIN, PAIR_MAX)));
        end else if (two) begin
          add_byte(8'($urandom_range(0, 255)));
          add_byte(8'($urandom_range(0, 255)));
        end else begin
          add_byte(8'($urandom_range(0, 127)));
        end
      end else if (pick < 55) begin
        add_byte(BYTE_ESC);
        case ($urandom_range(0, 2))
          0: add_byte(CH_K);
          1: begin
            add_byte(CH_DOLLAR);
            add_byte(CH_B);
          end
          default: begin
            add_byte(CH_DOLLAR);
            add_byte(CH_AT);
          end
        endcase
        two = 1'b1;
      end else if (pick < 68) begin
        add_byte(BYTE_ESC);
        case ($urandom_range(0, 2))
          0: add_byte(CH_H);
          1: begin
            add_byte(CH_LPAREN);
            add_byte(CH_B);
          end
          default: begin
            add_byte(CH_LPAREN);
            add_byte(CH_J);
          end
        endcase
        two = 1'b0;
      end else if (pick < 74) begin
        add_byte($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
        two = 1'b0;
      end else if (pick < 82) begin
        add_byte(BYTE_ESC);
        case ($urandom_range(0, 2))
          0: add_byte(CH_DOLLAR);
          1: add_byte(CH_LPAREN);
          default: ;
        endcase
        add_byte(8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        add_byte(8'($urandom_range(128, 255)));
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
    end
    // cut the last unit short now and then
    if ($urandom_range(0, 99) < 20 && stream_q.size() > 1) void'(stream_q.pop_back());
  endtask

  initial begin
    int target;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.byte_value    <= '0;
    in_ch.end_of_stream <= 1'b0;
    send_idle  = 0;
    recv_stall = 0;
    sent       = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // plain chars, then a high byte halts the rest of the stream
    stream_q = '{8'h41, 8'h00, 8'h7f, 8'h80, 8'hff};
    send_stream();
    // pairs at both range ends, LF leaves two-byte mode, bad lead with ESC as trail
    stream_q = '{BYTE_ESC, CH_DOLLAR, CH_B, 8'h21, 8'h21, 8'h7e, 8'h7e, BYTE_LF,
                 BYTE_ESC, CH_K, 8'h20, BYTE_ESC};
    send_stream();
    // lead byte as the final byte
    stream_q = '{BYTE_ESC, CH_DOLLAR, CH_AT, 8'h30};
    send_stream();
    // escapes cut short
    stream_q = '{BYTE_ESC, CH_LPAREN};
    send_stream();
    stream_q = '{BYTE_ESC};
    send_stream();
    // unknown escape
    stream_q = '{BYTE_ESC, 8'h5a};
    send_stream();
    // CR, ESC ( J, and ESC H ending the stream
    stream_q = '{BYTE_CR, BYTE_ESC, CH_LPAREN, CH_J, BYTE_ESC, CH_H};
    send_stream();

    target = sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 56; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 56; end
        default: begin send_idle = 11; recv_stall = 11; end
      endcase
      target += PHASE_SIZE;
      while (sent < target) begin
        make_stream();
        send_stream();
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
